// ===== hdl/ksg_pkg.sv =====
package ksg_pkg;

	// Table geometry and session counter width.
	localparam int TABLE_SLOTS  = 16;
	localparam int SESSION_BITS = 16;

	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);

	// Fixed field widths of the record and result channels.
	localparam int KEY_W      = 32;
	localparam int TIME_W     = 32;
	localparam int POS_W      = 24;
	localparam int SLOT_OUT_W = 4;
	localparam int SESS_OUT_W = 16;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register index, taken from paddr[2].
	localparam logic REG_GAP_LIMIT = 1'b0;

	localparam logic [SESSION_BITS-1:0] SESSION_MAX = '1;

endpackage

// ===== hdl/ksg_rec_if.sv =====
interface ksg_rec_if import ksg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KEY_W-1:0]  group_key;
	logic [TIME_W-1:0] record_time;
	logic [POS_W-1:0]  record_position;

	modport source (output valid, group_key, record_time, record_position, input ready);
	modport sink   (input valid, group_key, record_time, record_position, output ready);
endinterface

// ===== hdl/ksg_res_if.sv =====
interface ksg_res_if import ksg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic [SESS_OUT_W-1:0] session_index;
	logic                  first_of_key;
	logic                  opens_session;
	logic                  table_full;
	logic [POS_W-1:0]      position_out;

	modport source (output valid, slot_index, session_index, first_of_key, opens_session,
		table_full, position_out, input ready);
	modport sink   (input valid, slot_index, session_index, first_of_key, opens_session,
		table_full, position_out, output ready);
endinterface

// ===== hdl/keyed_session_grouper.sv =====
// A request accepted into the input register is looked up and registered in the result
// register, which drives the result channel. Throughput: one request per cycle while
// the result channel takes results, set by the slot lookup and table update over the
// flip-flop slot table; a stalled result channel holds at most one extra request.
// Reset (arst_n, asynchronous, active low) empties the slot table, clears gap_limit to 0
// and drops any request in flight; slot contents are not cleared.
module keyed_session_grouper import ksg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	ksg_rec_if.sink            records,
	ksg_res_if.source          results,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] rtime;
		logic [POS_W-1:0]  pos;
	} rec_t;

	typedef struct packed {
		logic [SLOT_W-1:0]       slot;
		logic [SESSION_BITS-1:0] session;
		logic                    first;
		logic                    opens;
		logic                    full;
		logic [POS_W-1:0]        pos;
	} res_t;

	// Configuration register. The low two address bits select a byte lane and are
	// ignored; paddr[2] is the register index.
	logic [TIME_W-1:0] gap_limit_q;
	logic              cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_GAP_LIMIT) ? gap_limit_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= '0;
		end else if (cfg_write && paddr[2] == REG_GAP_LIMIT) begin
			gap_limit_q <= pwdata;
		end
	end

	// Input register stage. A request moves on to the result register when the result
	// register is empty or being drained. While a finished result waits, the input
	// register can still take one more request and then holds it until the result
	// is taken.
	rec_t rec_s1;
	logic rec_valid_s1;
	res_t res_s2;
	logic res_valid_s2;
	logic advance;

	assign advance       = rec_valid_s1 && (!res_valid_s2 || results.ready);
	assign records.ready = !rec_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_s1 <= 1'b0;
		end else if (records.ready) begin
			rec_valid_s1 <= records.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (records.ready && records.valid) begin
			rec_s1.key   <= records.group_key;
			rec_s1.rtime <= records.record_time;
			rec_s1.pos   <= records.record_position;
		end
	end

	// Slot table. Keys are compared in parallel against every occupied slot; the time
	// and session of the matching slot are read at that one address.
	logic [KEY_W-1:0]        key_q  [TABLE_SLOTS];
	logic [TIME_W-1:0]       time_q [TABLE_SLOTS];
	logic [SESSION_BITS-1:0] sess_q [TABLE_SLOTS];
	logic [CNT_W-1:0]        slots_used_q;

	logic [TABLE_SLOTS-1:0]  hit_vec;
	logic                    hit_any;
	logic [SLOT_W-1:0]       hit_idx;
	logic [SLOT_W-1:0]       new_idx;
	logic                    tbl_full;
	logic [TIME_W-1:0]       last_time;
	logic [SESSION_BITS-1:0] cur_sess;
	logic [SESSION_BITS-1:0] next_sess;
	logic [TIME_W:0]         diff;
	logic                    joins;
	res_t                    res_d;

	always_comb begin
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			hit_vec[i] = (CNT_W'(i) < slots_used_q) && (key_q[i] == rec_s1.key);
		end
		hit_any = |hit_vec;

		// Keys are unique in the table, but the lowest match wins anyway.
		hit_idx = '0;
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = SLOT_W'(i);
			end
		end

		tbl_full  = (slots_used_q == CNT_W'(TABLE_SLOTS));
		new_idx   = slots_used_q[SLOT_W-1:0];
		last_time = time_q[hit_idx];
		cur_sess  = sess_q[hit_idx];

		// The difference is a 33-bit signed value; a negative one is below any limit.
		diff      = {1'b0, rec_s1.rtime} - {1'b0, last_time};
		joins     = diff[TIME_W] || (diff[TIME_W-1:0] < gap_limit_q);
		next_sess = (cur_sess == SESSION_MAX) ? cur_sess : cur_sess + 1'b1;

		res_d.pos = rec_s1.pos;
		priority if (hit_any) begin
			res_d.slot    = hit_idx;
			res_d.session = joins ? cur_sess : next_sess;
			res_d.first   = 1'b0;
			res_d.opens   = !joins;
			res_d.full    = 1'b0;
		end else if (!tbl_full) begin
			res_d.slot    = new_idx;
			res_d.session = '0;
			res_d.first   = 1'b1;
			res_d.opens   = 1'b1;
			res_d.full    = 1'b0;
		end else begin
			// A new key with no free slot leaves the table untouched.
			res_d.slot    = '0;
			res_d.session = '0;
			res_d.first   = 1'b0;
			res_d.opens   = 1'b0;
			res_d.full    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (hit_any) begin
				time_q[hit_idx] <= rec_s1.rtime;
				if (!joins) begin
					sess_q[hit_idx] <= next_sess;
				end
			end else if (!tbl_full) begin
				key_q[new_idx]  <= rec_s1.key;
				time_q[new_idx] <= rec_s1.rtime;
				sess_q[new_idx] <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_used_q <= '0;
		end else if (advance && !hit_any && !tbl_full) begin
			slots_used_q <= slots_used_q + 1'b1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (results.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	// The slot and session fields are fitted to the fixed port widths.
	logic [SLOT_W+SLOT_OUT_W-1:0]       slot_ext;
	logic [SESSION_BITS+SESS_OUT_W-1:0] sess_ext;

	assign slot_ext = {{SLOT_OUT_W{1'b0}}, res_s2.slot};
	assign sess_ext = {{SESS_OUT_W{1'b0}}, res_s2.session};

	assign results.valid         = res_valid_s2;
	assign results.slot_index    = slot_ext[SLOT_OUT_W-1:0];
	assign results.session_index = sess_ext[SESS_OUT_W-1:0];
	assign results.first_of_key  = res_s2.first;
	assign results.opens_session = res_s2.opens;
	assign results.table_full    = res_s2.full;
	assign results.position_out  = res_s2.pos;

endmodule

// ===== verif/tb_keyed_session_grouper.sv =====
module tb_keyed_session_grouper import ksg_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// The register map has one entry. The register index sits in paddr[2].
	localparam logic [PADDR_W-1:0] GAP_LIMIT_ADDR = {REG_GAP_LIMIT, 2'b00};

	// Fewer than 500 requests, each of which can wait out a long gap on the input
	// side and a long stall on the result side. The limit leaves a wide margin.
	localparam int CYCLE_LIMIT = 200_000;

	// One result of the grouper, as it appears on the result channel.
	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot_index;
		logic [SESS_OUT_W-1:0] session_index;
		logic                  first_of_key;
		logic                  opens_session;
		logic                  table_full;
		logic [POS_W-1:0]      position_out;
	} grouping_t;

	// The session book keeps its own copy of the slot table and of gap_limit.
	// For every accepted request it works out the result that the block must
	// return. Results leave in order, so one queue of expectations is enough.
	class ksg_session_book;
		logic [KEY_W-1:0]        slot_key  [TABLE_SLOTS];
		logic [TIME_W-1:0]       slot_time [TABLE_SLOTS];
		logic [SESSION_BITS-1:0] slot_sess [TABLE_SLOTS];
		int                      used;
		logic [TIME_W-1:0]       gap_limit;
		grouping_t               pending_results[$];
		int                      failures;

		function new();
			used      = 0;
			gap_limit = '0;
			failures  = 0;
		endfunction

		function void note_record(logic [KEY_W-1:0] key, logic [TIME_W-1:0] stamp,
				logic [POS_W-1:0] pos);
			grouping_t                want;
			int                       hit;
			logic signed [TIME_W+1:0] lapse;
			want = '0;
			want.position_out = pos;
			hit = -1;
			for (int i = 0; i < used; i++) begin
				if (hit < 0 && slot_key[i] == key)
					hit = i;
			end
			if (hit < 0) begin
				if (used < TABLE_SLOTS) begin
					slot_key[used]     = key;
					slot_time[used]    = stamp;
					slot_sess[used]    = '0;
					want.slot_index    = SLOT_OUT_W'(used);
					want.first_of_key  = 1'b1;
					want.opens_session = 1'b1;
					used++;
				end else begin
					want.table_full = 1'b1;
				end
			end else begin
				// The difference is taken wide enough that a timestamp going backwards
				// stays negative, and therefore below any gap limit.
				lapse = $signed({2'b00, stamp}) - $signed({2'b00, slot_time[hit]});
				if (lapse >= $signed({2'b00, gap_limit})) begin
					want.opens_session = 1'b1;
					if (slot_sess[hit] != SESSION_MAX)
						slot_sess[hit]++;
				end
				slot_time[hit]     = stamp;
				want.slot_index    = SLOT_OUT_W'(hit);
				want.session_index = SESS_OUT_W'(slot_sess[hit]);
			end
			pending_results = {pending_results, want};
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				failures++;
			end
		endfunction

		function void check_result(grouping_t got);
			grouping_t want;
			if (pending_results.size() == 0) begin
				$error("result with no request waiting for it: slot %0d, position 0x%0h",
					got.slot_index, got.position_out);
				failures++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("slot_index", want.slot_index, got.slot_index);
			compare_field("session_index", want.session_index, got.session_index);
			compare_field("first_of_key", want.first_of_key, got.first_of_key);
			compare_field("opens_session", want.opens_session, got.opens_session);
			compare_field("table_full", want.table_full, got.table_full);
			compare_field("position_out", want.position_out, got.position_out);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	ksg_rec_if rec_ch();
	ksg_res_if res_ch();

	ksg_session_book book = new();

	// While this flag is set, neither side inserts gaps. This gives stretches of
	// back-to-back traffic in which the block runs at its full rate.
	bit steady_flow = 1'b0;
	int stall_left  = 0;
	int cycle_count = 0;

	keyed_session_grouper i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.records (rec_ch),
		.results (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Idle length for either side. Most gaps are zero or short. A few are long,
	// so that pauses land on every phase of the block's pipeline.
	function automatic int pick_gap();
		int roll;
		if (steady_flow)
			return 0;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Result side. Outputs are sampled right after the rising edge, before any
	// register in the block has moved, so the values seen are those of the edge
	// itself. Ready is held high for a while and then dropped for a random stall.
	always @(posedge clk) begin
		grouping_t seen;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				seen.slot_index    = res_ch.slot_index;
				seen.session_index = res_ch.session_index;
				seen.first_of_key  = res_ch.first_of_key;
				seen.opens_session = res_ch.opens_session;
				seen.table_full    = res_ch.table_full;
				seen.position_out  = res_ch.position_out;
				book.check_result(seen);
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// A hang anywhere (lost result, stuck ready) ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_keyed_session_grouper: done, errors");
			$finish;
		end
	end

	// Offers one request after an optional idle gap and returns at the edge at
	// which it is taken. Valid is left high. The next call either keeps it high
	// with new content or drops it for a gap, so only one assignment lands per edge.
	task automatic send_record(logic [KEY_W-1:0] key, logic [TIME_W-1:0] stamp,
			logic [POS_W-1:0] pos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			rec_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rec_ch.valid           <= 1'b1;
		rec_ch.group_key       <= key;
		rec_ch.record_time     <= stamp;
		rec_ch.record_position <= pos;
		do @(posedge clk); while (!rec_ch.ready);
		book.note_record(key, stamp, pos);
	endtask

	task automatic stop_records();
		rec_ch.valid <= 1'b0;
	endtask

	// Every request yields exactly one result. Once the queue is empty, the
	// block holds nothing in flight.
	task automatic wait_drained();
		while (book.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Writes gap_limit through the configuration port and reads it back.
	task automatic set_gap_limit(logic [TIME_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= GAP_LIMIT_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		book.gap_limit = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			$error("gap_limit read back: expected 0x%0h, got 0x%0h", value, prdata);
			book.failures++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly records of keys that already hold a slot, with timestamps placed
	// just below, at and just above the gap boundary, stepping backwards, a
	// little forward, or anywhere. About one in ten carries a fresh key. These
	// fill the table and, once it is full, exercise the drop path.
	task automatic send_random();
		int               slot;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] stamp;
		logic [TIME_W-1:0] last;
		if (book.used == 0 || $urandom_range(99) < 10) begin
			key   = $urandom;
			stamp = $urandom;
		end else begin
			slot = $urandom_range(book.used - 1);
			key  = book.slot_key[slot];
			last = book.slot_time[slot];
			case ($urandom_range(5))
				0: stamp = last + book.gap_limit - 32'd1;
				1: stamp = last + book.gap_limit;
				2: stamp = last + book.gap_limit + 32'd1;
				3: stamp = last - TIME_W'($urandom_range(1000));
				4: stamp = last + TIME_W'($urandom_range(64));
				default: stamp = $urandom;
			endcase
		end
		send_record(key, stamp, POS_W'($urandom));
	endtask

	initial begin
		logic [TIME_W-1:0] phase_limit [5];
		logic [KEY_W-1:0]  key_a;
		logic [KEY_W-1:0]  key_b;
		logic [KEY_W-1:0]  key_c;
		logic [KEY_W-1:0]  key_d;

		arst_n                 = 1'b0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		rec_ch.valid           = 1'b0;
		rec_ch.group_key       = '0;
		rec_ch.record_time     = '0;
		rec_ch.record_position = '0;
		res_ch.ready           = 1'b0;

		key_a = 32'h0000_0000;
		key_b = 32'hFFFF_FFFF;
		key_c = 32'hA5A5_A5A5;
		key_d = 32'h5A5A_5A5A;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, first with a zero gap limit. A repeated timestamp then
		// opens a new session, and only a step backwards keeps the old one.
		set_gap_limit(32'd0);
		send_record(key_a, 32'h0000_0000, 24'h00_0000);
		send_record(key_b, 32'hFFFF_FFFF, 24'hFF_FFFF);
		send_record(key_a, 32'h0000_0000, 24'h00_0001);
		send_record(key_b, 32'h0000_0000, 24'h80_0000);
		send_record(key_b, 32'h0000_0000, 24'h7F_FFFF);
		send_record(key_a, 32'hFFFF_FFFF, 24'h00_0002);
		send_record(key_c, 32'h1234_5678, 24'h55_5555);
		send_record(key_d, 32'h8000_0000, 24'hAA_AAAA);
		stop_records();

		// With the widest gap limit, only a forward step of the full range
		// counts as a break. A step backwards still joins.
		wait_drained();
		set_gap_limit(32'hFFFF_FFFF);
		send_record(key_a, 32'h0000_0000, 24'h00_0003);
		send_record(key_a, 32'hFFFF_FFFF, 24'h00_0004);
		send_record(key_a, 32'hFFFF_FFFE, 24'h00_0005);
		send_record(key_c, 32'h1234_5679, 24'h00_0006);
		stop_records();

		// A mid-range limit checked at the boundary: one below joins, while
		// equal and one above open a session.
		wait_drained();
		set_gap_limit(32'd100);
		send_record(key_d, 32'h8000_0063, 24'h00_0007);
		send_record(key_d, 32'h8000_00C7, 24'h00_0008);
		send_record(key_d, 32'h8000_012C, 24'h00_0009);
		stop_records();

		// Random part in phases, each with its own gap limit, the extremes among
		// them. The middle phase runs without gaps on either side.
		phase_limit = '{32'd1000, $urandom, 32'd0, 32'hFFFF_FFFF, 32'd16};
		for (int p = 0; p < 5; p++) begin
			wait_drained();
			set_gap_limit(phase_limit[p]);
			steady_flow = (p == 2);
			repeat (90) send_random();
			stop_records();
		end
		steady_flow = 1'b0;

		// Let the last results arrive, then keep watching for anything
		// that should not come.
		wait_drained();
		repeat (8) @(posedge clk);
		if (book.failures == 0)
			$display("tb_keyed_session_grouper: done, clean");
		else
			$display("tb_keyed_session_grouper: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/ksg_pkg.sv
hdl/ksg_rec_if.sv
hdl/ksg_res_if.sv
hdl/keyed_session_grouper.sv
verif/tb_keyed_session_grouper.sv
